[hdl/art_pkg.sv]
// Shared types and constants for the acknowledge/retransmit tracker.
`timescale 1ns / 1ps

package art_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W        = 2;
    localparam int ID_W         = 8;
    localparam int TIME_W       = 32;
    localparam int TIMEOUT_W    = 16;
    localparam int EVENT_W      = 3;
    localparam int SLOT_FIELD_W = 4;

    // At most this many retransmits come out of one tick
    localparam int MAX_RESULTS  = 16;
    localparam int COUNT_W      = 5;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_DATA = 2'd2,
        CMD_TICK = 2'd3
    } t_cmd;

    // Result events
    typedef enum logic [EVENT_W-1:0] {
        EV_TRANSMIT   = 3'd0,
        EV_CONFIRMED  = 3'd1,
        EV_RETRANSMIT = 3'd2,
        EV_SEND_ACK   = 3'd3,
        EV_DROP       = 3'd4
    } t_event;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_FLUSH
    } t_state;

    // One result word
    typedef struct packed {
        t_event                  ev;
        logic [ID_W-1:0]         id;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    last;
    } t_result;

    // Flags from the shared compare unit
    typedef struct packed {
        logic expired;
        logic id_hit;
    } t_match;

endpackage

[hdl/art_slot_mem.sv]
// Slot table storage: message ID and send time per slot, registered read.
`timescale 1ns / 1ps

module art_slot_mem import art_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we_id,
    input  logic              i_we_time,
    input  logic [AW-1:0]     i_addr,
    input  logic [ID_W-1:0]   i_wr_id,
    input  logic [TIME_W-1:0] i_wr_time,
    output logic [ID_W-1:0]   o_rd_id,
    output logic [TIME_W-1:0] o_rd_time
);

    logic [ID_W-1:0]   r_id_mem   [DEPTH];
    logic [TIME_W-1:0] r_time_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we_id) begin
            r_id_mem[i_addr] <= i_wr_id;
        end
        if (i_we_time) begin
            r_time_mem[i_addr] <= i_wr_time;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_id   <= r_id_mem[i_addr];
        o_rd_time <= r_time_mem[i_addr];
    end

endmodule

[hdl/art_match_unit.sv]
// Shared compare unit: wrapping age against timeout, and ID match.
`timescale 1ns / 1ps

module art_match_unit import art_pkg::*; (
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic [TIME_W-1:0]    i_sent_ms,
    input  logic [TIMEOUT_W-1:0] i_timeout_ms,
    input  logic [ID_W-1:0]      i_slot_id,
    input  logic [ID_W-1:0]      i_msg_id,
    output t_match               o_match
);

    logic [TIME_W-1:0] age;

    // Age wraps mod 2^32
    assign age = i_now_ms - i_sent_ms;

    assign o_match.expired = age > TIME_W'(i_timeout_ms);
    assign o_match.id_hit  = (i_slot_id == i_msg_id);

endmodule

[hdl/art_out_reg.sv]
// Output register: holds one result word until the receiver takes it.
`timescale 1ns / 1ps

module art_out_reg import art_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_word,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_word,
    output logic    o_free
);

    logic    r_valid;
    t_result r_word;

    // Room for a new word when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[hdl/ack_retransmit_tracker_top.sv]
// Top level of the acknowledge/retransmit tracker: sequencer and slot state.
`timescale 1ns / 1ps
//
// Tracks sent messages awaiting acknowledgement in PENDING_DEPTH slots.
// Input channel (i_in_valid/o_in_ready) takes one command word: send new,
// ACK received, data message received, or time tick. Output channel
// (o_out_valid/i_out_ready) returns zero or more result words per command;
// o_last marks the final word of a command. Config channel writes
// timeout_ms; the user must do so only while the block is idle, which the
// block itself does not enforce. The config channel is always ready.
// One command is in work at a time; o_in_ready is high only when idle.
// A small sequencer walks the slots one per cycle in the SCAN state, and
// each occupied slot that an ACK or tick must inspect also passes through
// the CHECK state for the table read and the shared age/ID compare.
// A finished word waits in the output register while the next command is
// accepted. If the receiver stalls, the tick walk holds at the next expired
// slot until the waiting word drains.
// Reset (synchronous, active low) empties the table, sets the next ID to 0
// and timeout_ms to 2000; the table storage itself needs no clearing.
//
module ack_retransmit_tracker_top import art_pkg::*; #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command input
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [ID_W-1:0]         i_msg_id,
    input  logic [TIME_W-1:0]       i_now_ms,
    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [EVENT_W-1:0]      o_event_res,
    output logic [ID_W-1:0]         o_out_id,
    output logic [SLOT_FIELD_W-1:0] o_slot,
    output logic                    o_last,
    // config write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [TIMEOUT_W-1:0]    i_cfg_timeout_ms
);

    localparam int SLOT_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int EXT_W  = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(PENDING_DEPTH - 1);

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic we_id;
        logic we_time;
        logic set_valid;
        logic clr_valid;
        logic hold_load;
        logic hold_clr;
        logic push;
        logic push_last;
        logic idx_inc;
        logic cnt_inc;
        logic id_inc;
    } t_ctrl;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [ID_W-1:0]       r_id;
    logic [TIME_W-1:0]     r_now;
    logic [SLOT_W-1:0]     r_idx;
    logic [PENDING_DEPTH-1:0] r_valid;
    logic [ID_W-1:0]       r_next_id;
    logic [TIMEOUT_W-1:0]  r_timeout;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_hold_valid;
    t_event                r_hold_ev;
    logic [ID_W-1:0]       r_hold_id;
    logic [SLOT_FIELD_W-1:0] r_hold_slot;

    t_ctrl                 ctrl;
    t_event                cand_ev;
    logic [ID_W-1:0]       cand_id;
    logic [SLOT_FIELD_W-1:0] cand_slot;

    logic [ID_W-1:0]       rd_id;
    logic [TIME_W-1:0]     rd_time;
    t_match                match;
    logic                  out_free;
    t_result               out_word;
    t_result               push_word;
    logic [EXT_W-1:0]      idx_ext;
    logic [SLOT_FIELD_W-1:0] idx_slot;
    logic                  last_slot;
    logic                  cur_valid;
    logic                  cap_hit;

    // Slot number as reported, modulo the field width
    assign idx_ext   = EXT_W'(r_idx);
    assign idx_slot  = idx_ext[SLOT_FIELD_W-1:0];
    assign last_slot = (r_idx == LAST_IDX);
    assign cur_valid = r_valid[r_idx];
    assign cap_hit   = (r_count == COUNT_W'(MAX_RESULTS - 1));

    // Table storage
    art_slot_mem #(
        .DEPTH (PENDING_DEPTH),
        .AW    (SLOT_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we_id   (ctrl.we_id),
        .i_we_time (ctrl.we_time),
        .i_addr    (r_idx),
        .i_wr_id   (r_next_id),
        .i_wr_time (r_now),
        .o_rd_id   (rd_id),
        .o_rd_time (rd_time)
    );

    // Shared age / ID compare
    art_match_unit u_match (
        .i_now_ms     (r_now),
        .i_sent_ms    (rd_time),
        .i_timeout_ms (r_timeout),
        .i_slot_id    (rd_id),
        .i_msg_id     (r_id),
        .o_match      (match)
    );

    // Result output register
    assign push_word = '{ev: r_hold_ev, id: r_hold_id, slot: r_hold_slot,
                         last: ctrl.push_last};

    art_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ctrl.push),
        .i_word  (push_word),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_word  (out_word),
        .o_free  (out_free)
    );

    assign o_event_res = out_word.ev;
    assign o_out_id    = out_word.id;
    assign o_slot      = out_word.slot;
    assign o_last      = out_word.last;
    assign o_in_ready  = ctrl.in_ready;
    assign o_cfg_ready = 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_cmd'(i_command) == CMD_DATA) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cmd == CMD_SEND) begin
                    if (!cur_valid || last_slot) begin
                        n_state = ST_FLUSH;
                    end
                end else if (cur_valid) begin
                    n_state = ST_CHECK;
                end else if (last_slot) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_CHECK: begin
                if (r_cmd == CMD_ACK && match.id_hit) begin
                    n_state = ST_FLUSH;
                end else if (r_cmd == CMD_TICK && match.expired) begin
                    if (!r_hold_valid || out_free) begin
                        n_state = (cap_hit || last_slot) ? ST_FLUSH : ST_SCAN;
                    end
                end else begin
                    n_state = last_slot ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_valid || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        ctrl      = '0;
        cand_ev   = EV_TRANSMIT;
        cand_id   = r_next_id;
        cand_slot = idx_slot;
        unique case (r_state)
            ST_IDLE: begin
                ctrl.in_ready = 1'b1;
                if (i_in_valid) begin
                    ctrl.accept   = 1'b1;
                    ctrl.hold_clr = 1'b1;
                    if (t_cmd'(i_command) == CMD_DATA) begin
                        ctrl.hold_load = 1'b1;
                        cand_ev        = EV_SEND_ACK;
                        cand_id        = i_msg_id;
                        cand_slot      = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cmd == CMD_SEND) begin
                    if (!cur_valid) begin
                        // lowest free slot takes the new message
                        ctrl.we_id     = 1'b1;
                        ctrl.we_time   = 1'b1;
                        ctrl.set_valid = 1'b1;
                        ctrl.id_inc    = 1'b1;
                        ctrl.hold_load = 1'b1;
                        cand_ev        = EV_TRANSMIT;
                    end else if (last_slot) begin
                        // table full
                        ctrl.hold_load = 1'b1;
                        cand_ev        = EV_DROP;
                        cand_slot      = '0;
                    end else begin
                        ctrl.idx_inc = 1'b1;
                    end
                end else if (!cur_valid && !last_slot) begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            ST_CHECK: begin
                if (r_cmd == CMD_ACK && match.id_hit) begin
                    ctrl.clr_valid = 1'b1;
                    ctrl.hold_load = 1'b1;
                    cand_ev        = EV_CONFIRMED;
                    cand_id        = r_id;
                end else if (r_cmd == CMD_TICK && match.expired) begin
                    if (!r_hold_valid || out_free) begin
                        // earlier retransmit goes out, this one waits in hold
                        ctrl.push      = r_hold_valid;
                        ctrl.we_time   = 1'b1;
                        ctrl.hold_load = 1'b1;
                        ctrl.cnt_inc   = 1'b1;
                        ctrl.idx_inc   = !(cap_hit || last_slot);
                        cand_ev        = EV_RETRANSMIT;
                        cand_id        = rd_id;
                    end
                end else if (!last_slot) begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (r_hold_valid && out_free) begin
                    ctrl.push      = 1'b1;
                    ctrl.push_last = 1'b1;
                    ctrl.hold_clr  = 1'b1;
                end
            end
            default: ctrl = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_next_id    <= '0;
            r_timeout    <= TIMEOUT_RESET;
            r_hold_valid <= 1'b0;
            r_idx        <= '0;
            r_count      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_timeout_ms;
            end
            if (ctrl.set_valid) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (ctrl.clr_valid) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (ctrl.id_inc) begin
                r_next_id <= r_next_id + 1'b1;
            end
            if (ctrl.hold_load) begin
                r_hold_valid <= 1'b1;
            end else if (ctrl.hold_clr) begin
                r_hold_valid <= 1'b0;
            end
            if (ctrl.accept) begin
                r_idx   <= '0;
                r_count <= '0;
            end else begin
                if (ctrl.idx_inc) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (ctrl.cnt_inc) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Command and hold payload
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_cmd <= t_cmd'(i_command);
            r_id  <= i_msg_id;
            r_now <= i_now_ms;
        end
        if (ctrl.hold_load) begin
            r_hold_ev   <= cand_ev;
            r_hold_id   <= cand_id;
            r_hold_slot <= cand_slot;
        end
    end

endmodule
